// File: sv/bile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bile_pkg
// Shared widths, request codes and result type for the bounded list engine.
// ----------------------------------------------------------------------------
package bile_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int VAL_W        = 32;
	localparam int REQ_W        = 3;
	localparam int POS_W        = 8;
	localparam int IDX_W        = 8;
	localparam int CNT_W        = 9;

	// Request codes; the two unused codes fall to a default arm
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 3'd0,
		REQ_POP   = 3'd1,
		REQ_GET   = 3'd2,
		REQ_FIND  = 3'd3,
		REQ_SORT  = 3'd4,
		REQ_CHECK = 3'd5
	} req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [VAL_W-1:0] value_out;
		logic [IDX_W-1:0]        found_index;
		logic [CNT_W-1:0]        count;
	} res_t;

endpackage

// File: sv/bounded_int_list_engine.sv
`timescale 1ns / 1ps
// Push, and a failed pop or get, go straight from idle to the done state; pop and
// get pass through a read state first; find and check-sorted read one entry per
// cycle, and sort walks the list in place. One request in service at a time: the
// next one is accepted in the cycle its result appears; a held result stalls.
// Reset: count clears to zero at once; the entry store is not cleared.
// ----------------------------------------------------------------------------
// bounded_int_list_engine
// Bounded list of signed words in one synchronous memory, with push, pop,
// get, find, in-place insertion sort and an ascending-order check.
// ----------------------------------------------------------------------------
module bounded_int_list_engine
	import bile_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [REQ_W-1:0]        req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    ok,
	output logic signed [VAL_W-1:0] value_out,
	output logic [IDX_W-1:0]        found_index,
	output logic [CNT_W-1:0]        count
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = (CW > POS_W) ? CW : POS_W;
	localparam int XW  = (CW > CNT_W) ? CW : CNT_W;
	localparam int IXW = (AW > IDX_W) ? AW : IDX_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_FIND,
		ST_CHECK,
		ST_SKEY,
		ST_SKEYW,
		ST_SCMP,
		ST_SPUT,
		ST_DONE
	} state_t;

	state_t                  state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [CW-1:0]           k_q, k_d;
	logic [AW-1:0]           j_q, j_d;
	logic signed [VAL_W-1:0] key_q, key_d;
	logic signed [VAL_W-1:0] prev_q, prev_d;
	logic                    rd_vld_s1, rd_vld_d;
	logic [AW-1:0]           rd_idx_s1, rd_idx_d;
	res_t                    res_q, res_d;
	logic                    out_valid_q, out_valid_d;
	res_t                    out_q, out_d;

	// Store ports
	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic signed [VAL_W-1:0] rdata_s1;
	logic                    mem_we, mem_re;
	logic [AW-1:0]           mem_wa, mem_ra;
	logic signed [VAL_W-1:0] mem_wd;

	// Widened views for compares and output masking
	logic [PW-1:0]  pos_w, cnt_w;
	logic [XW-1:0]  cnt_x;
	logic [IXW-1:0] fidx_w;
	logic [CW-1:0]  count_m1;
	logic [AW-1:0]  j_m1;

	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign cnt_x    = XW'(count_q);
	assign fidx_w   = IXW'(rd_idx_s1);
	assign count_m1 = count_q - 1'b1;
	assign j_m1     = j_q - 1'b1;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = out_q.ok;
	assign value_out   = out_q.value_out;
	assign found_index = out_q.found_index;
	assign count       = out_q.count;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_ra];
		end
	end

	// Sequence requests over the store; only one access per address per cycle
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		k_d         = k_q;
		j_d         = j_q;
		key_d       = key_q;
		prev_d      = prev_q;
		res_d       = res_q;
		rd_vld_d    = 1'b0;
		rd_idx_d    = rd_idx_s1;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		mem_we      = 1'b0;
		mem_wa      = '0;
		mem_wd      = '0;
		mem_re      = 1'b0;
		mem_ra      = '0;

		// drop the output once taken
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_d = '0;
					unique case (req_type)
						REQ_PUSH: begin
							if (count_q < CW'(CAPACITY)) begin
								mem_we    = 1'b1;
								mem_wa    = count_q[AW-1:0];
								mem_wd    = value;
								count_d   = count_q + 1'b1;
								res_d.ok  = 1'b1;
							end
							state_d = ST_DONE;
						end
						REQ_POP: begin
							if (count_q != '0) begin
								count_d  = count_m1;
								mem_re   = 1'b1;
								mem_ra   = count_m1[AW-1:0];
								res_d.ok = 1'b1;
								state_d  = ST_RD;
							end else begin
								state_d = ST_DONE;
							end
						end
						REQ_GET: begin
							if (pos_w < cnt_w) begin
								mem_re   = 1'b1;
								mem_ra   = pos_w[AW-1:0];
								res_d.ok = 1'b1;
								state_d  = ST_RD;
							end else begin
								state_d = ST_DONE;
							end
						end
						REQ_FIND: begin
							key_d   = value;
							k_d     = '0;
							state_d = ST_FIND;
						end
						REQ_SORT: begin
							k_d      = CW'(1);
							res_d.ok = 1'b1;
							state_d  = ST_SKEY;
						end
						REQ_CHECK: begin
							k_d      = '0;
							res_d.ok = 1'b1;
							state_d  = ST_CHECK;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			// capture the pop or get word
			ST_RD: begin
				res_d.value_out = rdata_s1;
				state_d         = ST_DONE;
			end

			// stream entries, compare the one read last cycle
			ST_FIND: begin
				if (rd_vld_s1 && (rdata_s1 == key_q)) begin
					res_d.ok          = 1'b1;
					res_d.found_index = fidx_w[IDX_W-1:0];
					state_d           = ST_DONE;
				end else if (k_q < count_q) begin
					mem_re   = 1'b1;
					mem_ra   = k_q[AW-1:0];
					rd_vld_d = 1'b1;
					rd_idx_d = k_q[AW-1:0];
					k_d      = k_q + 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end

			// stream entries, compare each against its predecessor
			ST_CHECK: begin
				if (rd_vld_s1 && (rd_idx_s1 != '0) && (prev_q > rdata_s1)) begin
					res_d.ok = 1'b0;
					state_d  = ST_DONE;
				end else begin
					if (rd_vld_s1) begin
						prev_d = rdata_s1;
					end
					if (k_q < count_q) begin
						mem_re   = 1'b1;
						mem_ra   = k_q[AW-1:0];
						rd_vld_d = 1'b1;
						rd_idx_d = k_q[AW-1:0];
						k_d      = k_q + 1'b1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end

			// fetch the next insertion key
			ST_SKEY: begin
				if (k_q < count_q) begin
					mem_re  = 1'b1;
					mem_ra  = k_q[AW-1:0];
					j_d     = k_q[AW-1:0];
					state_d = ST_SKEYW;
				end else begin
					state_d = ST_DONE;
				end
			end

			// hold the key, fetch its left neighbor
			ST_SKEYW: begin
				key_d   = rdata_s1;
				mem_re  = 1'b1;
				mem_ra  = j_m1;
				state_d = ST_SCMP;
			end

			// shift a larger neighbor right, or drop the key in place
			ST_SCMP: begin
				if (rdata_s1 > key_q) begin
					mem_we = 1'b1;
					mem_wa = j_q;
					mem_wd = rdata_s1;
					j_d    = j_m1;
					if (j_m1 != '0) begin
						mem_re = 1'b1;
						mem_ra = j_m1 - 1'b1;
					end else begin
						state_d = ST_SPUT;
					end
				end else begin
					mem_we  = 1'b1;
					mem_wa  = j_q;
					mem_wd  = key_q;
					k_d     = k_q + 1'b1;
					state_d = ST_SKEY;
				end
			end

			// key goes to the head of the list
			ST_SPUT: begin
				mem_we  = 1'b1;
				mem_wa  = j_q;
				mem_wd  = key_q;
				k_d     = k_q + 1'b1;
				state_d = ST_SKEY;
			end

			// hand the result to the output register when it is free
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_d       = res_q;
					out_d.count = cnt_x[CNT_W-1:0];
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_vld_s1   <= rd_vld_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		k_q       <= k_d;
		j_q       <= j_d;
		key_q     <= key_d;
		prev_q    <= prev_d;
		rd_idx_s1 <= rd_idx_d;
		res_q     <= res_d;
		out_q     <= out_d;
	end

endmodule
